>>> design/gpx_pkg.sv
// ----------------------------------------------------------------------------
// gpx_pkg
// Shared types, codes and helper functions for the GPX track point extractor.
// ----------------------------------------------------------------------------
package gpx_pkg;

    // Tag name letters kept for matching (5 to 8)
    localparam int NAME_BYTES = 5;
    localparam int NAME_IDX_W = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
    localparam int ATTR_BYTES = 3;

    // Command queue between parser and beat generator
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // Configuration port
    localparam int               ADDR_W          = 3;
    localparam logic [ADDR_W-1:0] ADDR_VALUE_LIMIT = 3'd0;
    localparam logic [7:0]       VALUE_LIMIT_RST = 8'd99;

    // Result kinds
    localparam logic [1:0] KIND_DATA       = 2'd0;
    localparam logic [1:0] KIND_END_FIELD  = 2'd1;
    localparam logic [1:0] KIND_END_RECORD = 2'd2;

    // Field codes
    localparam logic [1:0] FIELD_LAT  = 2'd0;
    localparam logic [1:0] FIELD_LON  = 2'd1;
    localparam logic [1:0] FIELD_ELE  = 2'd2;
    localparam logic [1:0] FIELD_TIME = 2'd3;

    localparam logic [2:0] ESC_LAST_STEP = 3'd6;

    typedef enum logic [3:0] {
        ST_TOP         = 4'd0,
        ST_TAGNAME     = 4'd1,
        ST_DECL        = 4'd2,
        ST_WS_TAG      = 4'd3,
        ST_ATTR_NAME   = 4'd4,
        ST_WS_ATTRNAME = 4'd5,
        ST_EQ          = 4'd6,
        ST_VAL_SQ      = 4'd7,
        ST_VAL_DQ      = 4'd8,
        ST_WS_EQ       = 4'd9,
        ST_CLOSING     = 4'd10
    } parse_state_t;

    typedef enum logic [1:0] {
        CMD_DATA       = 2'd0,
        CMD_END_FIELD  = 2'd1,
        CMD_END_RECORD = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic [1:0] field;
    } cmd_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    // "&comma;"
    function automatic logic [7:0] escape_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = "&";
            3'd1:    b = "c";
            3'd2:    b = "o";
            3'd3:    b = "m";
            3'd4:    b = "m";
            3'd5:    b = "a";
            3'd6:    b = ";";
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

>>> design/gpx_track_point_extractor.sv
// ----------------------------------------------------------------------------
// gpx_track_point_extractor
// Pulls lat/lon/ele/time fields of GPX track points out of a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one text byte per beat; out_valid/out_ready carry
//   one result beat (out_byte, field_id, out_kind, last). last marks the final
//   beat caused by an input byte; bytes that cause nothing give no beat.
//   The parser takes one byte per cycle and pushes at most one command into a
//   four-entry queue; the beat generator drains it at one beat per cycle
//   while the receiver takes beats. Commands pass through the queue, then the
//   output register. Throughput: one byte per cycle while the queue has room;
//   a comma in a field expands to seven beats ("&comma;") and an end of
//   record to two, so in_ready drops only once four commands are queued.
//   When the receiver stalls, the output beat holds and the queue fills,
//   after which in_ready goes low. Reset clears parser state, queue and
//   output valid; value_limit returns to 99. value_limit sits at APB address
//   0; the user must write it only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module gpx_track_point_extractor (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                in_byte,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                out_byte,
    output logic [1:0]                field_id,
    output logic [1:0]                out_kind,
    output logic                      last,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [gpx_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import gpx_pkg::*;

    logic [7:0] value_limit_reg;
    logic       cfg_write;
    logic       q_full, q_empty, cmd_push, cmd_pop;
    cmd_t       cmd, head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == ADDR_VALUE_LIMIT) ? {24'd0, value_limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_limit_reg <= VALUE_LIMIT_RST;
        end
        else if (cfg_write && (paddr == ADDR_VALUE_LIMIT))
        begin
            value_limit_reg <= pwdata[7:0];
        end
    end

    gpx_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .value_limit (value_limit_reg),
        .q_full      (q_full),
        .cmd_push    (cmd_push),
        .cmd         (cmd)
    );

    gpx_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd),
        .pop       (cmd_pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    gpx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (cmd_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .field_id  (field_id),
        .out_kind  (out_kind),
        .last      (last)
    );

endmodule

>>> design/gpx_front.sv
// ----------------------------------------------------------------------------
// gpx_front
// XML parser: one byte per cycle while the queue has room, tracks tags and
// attributes, pushes at most one command per byte into the command queue.
// ----------------------------------------------------------------------------
module gpx_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic [7:0]    value_limit,
    input  logic          q_full,
    output logic          cmd_push,
    output gpx_pkg::cmd_t cmd
);
    import gpx_pkg::*;

    parse_state_t state_reg, state_next;
    logic [7:0]   tag_prefix_reg  [NAME_BYTES];
    logic [7:0]   tag_prefix_next [NAME_BYTES];
    logic [6:0]   tag_length_reg, tag_length_next;
    logic [7:0]   attr_prefix_reg  [ATTR_BYTES];
    logic [7:0]   attr_prefix_next [ATTR_BYTES];
    logic [6:0]   attr_length_reg, attr_length_next;
    logic [7:0]   value_count_reg, value_count_next;
    logic         trkpt_reg, trkpt_next;
    logic         ele_reg, ele_next;
    logic         time_reg, time_next;

    logic       accept;
    logic [7:0] c;
    logic [7:0] lc [NAME_BYTES];
    logic       tag_trkpt, tag_ele_pre, tag_ele_exact, tag_time_pre, tag_time_exact;
    logic       attr_lat, attr_lon, quote_hit;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign c        = in_byte;

    always_comb
    begin
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            lc[i] = tag_prefix_reg[i] | 8'h20;
        end
    end

    assign tag_trkpt     = (tag_length_reg >= 7'd5) &&
                           ({lc[0], lc[1], lc[2], lc[3], lc[4]} == "trkpt");
    assign tag_ele_pre   = (tag_length_reg >= 7'd3) && ({lc[0], lc[1], lc[2]} == "ele");
    assign tag_ele_exact = tag_ele_pre && (tag_length_reg == 7'd3);
    assign tag_time_pre  = (tag_length_reg >= 7'd4) &&
                           ({lc[0], lc[1], lc[2], lc[3]} == "time");
    assign tag_time_exact = tag_time_pre && (tag_length_reg == 7'd4);

    assign attr_lat = (attr_length_reg >= 7'd3) &&
        ({attr_prefix_reg[0], attr_prefix_reg[1], attr_prefix_reg[2]} == "lat");
    assign attr_lon = (attr_length_reg >= 7'd3) &&
        ({attr_prefix_reg[0], attr_prefix_reg[1], attr_prefix_reg[2]} == "lon");
    assign quote_hit = (state_reg == ST_VAL_SQ) ? (c == "'") : (c == "\"");

    always_comb
    begin
        state_next       = state_reg;
        tag_prefix_next  = tag_prefix_reg;
        tag_length_next  = tag_length_reg;
        attr_prefix_next = attr_prefix_reg;
        attr_length_next = attr_length_reg;
        value_count_next = value_count_reg;
        trkpt_next       = trkpt_reg;
        ele_next         = ele_reg;
        time_next        = time_reg;
        cmd_push         = 1'b0;
        cmd.kind         = CMD_DATA;
        cmd.data         = c;
        cmd.field        = FIELD_LAT;

        if (accept)
        begin
            unique case (state_reg)
                ST_TOP:
                begin
                    if (c == "<")
                    begin
                        if (trkpt_reg && ele_reg)
                        begin
                            cmd_push  = 1'b1;
                            cmd.kind  = CMD_END_FIELD;
                            cmd.field = FIELD_ELE;
                            ele_next  = 1'b0;
                        end
                        else if (trkpt_reg && time_reg)
                        begin
                            cmd_push  = 1'b1;
                            cmd.kind  = CMD_END_RECORD;
                            cmd.field = FIELD_TIME;
                            time_next = 1'b0;
                        end
                        for (int i = 0; i < NAME_BYTES; i++)
                        begin
                            tag_prefix_next[i] = 8'd0;
                        end
                        tag_length_next = 7'd0;
                        state_next      = ST_TAGNAME;
                    end
                    else if (trkpt_reg && ele_reg)
                    begin
                        cmd_push  = 1'b1;
                        cmd.field = FIELD_ELE;
                    end
                    else if (trkpt_reg && time_reg)
                    begin
                        cmd_push  = 1'b1;
                        cmd.field = FIELD_TIME;
                    end
                end
                ST_TAGNAME:
                begin
                    if (is_letter(c))
                    begin
                        if (tag_length_reg < 7'(NAME_BYTES))
                        begin
                            tag_prefix_next[tag_length_reg[NAME_IDX_W-1:0]] = c;
                        end
                        if (tag_length_reg != 7'd127)
                        begin
                            tag_length_next = tag_length_reg + 7'd1;
                        end
                    end
                    else if (is_space(c))
                    begin
                        if (tag_trkpt)
                        begin
                            trkpt_next = 1'b1;
                        end
                        if (tag_ele_exact)
                        begin
                            ele_next = 1'b1;
                        end
                        else if (tag_time_exact)
                        begin
                            time_next = 1'b1;
                        end
                        state_next = ST_WS_TAG;
                    end
                    else if (c == ">")
                    begin
                        // on '>' a prefix match is enough
                        if (tag_ele_pre)
                        begin
                            ele_next = 1'b1;
                        end
                        else if (tag_time_pre && trkpt_reg)
                        begin
                            time_next = 1'b1;
                        end
                        state_next = ST_TOP;
                    end
                    else if ((c == "!") || (c == "?"))
                    begin
                        state_next = ST_DECL;
                    end
                    else if (c == "/")
                    begin
                        state_next = ST_CLOSING;
                    end
                end
                ST_DECL, ST_CLOSING:
                begin
                    if (c == ">")
                    begin
                        state_next = ST_TOP;
                    end
                end
                ST_WS_TAG:
                begin
                    if (tag_trkpt && is_letter(c))
                    begin
                        attr_prefix_next[0] = c;
                        attr_prefix_next[1] = 8'd0;
                        attr_prefix_next[2] = 8'd0;
                        attr_length_next    = 7'd1;
                        state_next          = ST_ATTR_NAME;
                    end
                    else if (c == ">")
                    begin
                        state_next = ST_TOP;
                    end
                end
                ST_ATTR_NAME:
                begin
                    if (is_letter(c))
                    begin
                        if (attr_length_reg < 7'(ATTR_BYTES))
                        begin
                            attr_prefix_next[attr_length_reg[1:0]] = c;
                        end
                        if (attr_length_reg != 7'd127)
                        begin
                            attr_length_next = attr_length_reg + 7'd1;
                        end
                    end
                    else if (is_space(c))
                    begin
                        state_next = ST_WS_ATTRNAME;
                    end
                    else if (c == "=")
                    begin
                        state_next = ST_EQ;
                    end
                    else if (c == ">")
                    begin
                        state_next = ST_TOP;
                    end
                end
                ST_WS_ATTRNAME:
                begin
                    if (c == "=")
                    begin
                        state_next = ST_EQ;
                    end
                end
                ST_EQ, ST_WS_EQ:
                begin
                    if (c == "'")
                    begin
                        value_count_next = 8'd0;
                        state_next       = ST_VAL_SQ;
                    end
                    else if (c == "\"")
                    begin
                        value_count_next = 8'd0;
                        state_next       = ST_VAL_DQ;
                    end
                    else if (is_space(c) && (state_reg == ST_EQ))
                    begin
                        state_next = ST_WS_EQ;
                    end
                end
                ST_VAL_SQ, ST_VAL_DQ:
                begin
                    cmd.field = attr_lat ? FIELD_LAT : FIELD_LON;
                    if (quote_hit)
                    begin
                        cmd_push = attr_lat || attr_lon;
                        cmd.kind = CMD_END_FIELD;
                        for (int i = 0; i < ATTR_BYTES; i++)
                        begin
                            attr_prefix_next[i] = 8'd0;
                        end
                        attr_length_next = 7'd0;
                        value_count_next = 8'd0;
                        state_next       = ST_WS_TAG;
                    end
                    else if (value_count_reg < value_limit)
                    begin
                        value_count_next = value_count_reg + 8'd1;
                        cmd_push         = attr_lat || attr_lon;
                    end
                end
                default:
                begin
                    state_next = ST_TOP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_TOP;
            for (int i = 0; i < NAME_BYTES; i++)
            begin
                tag_prefix_reg[i] <= 8'd0;
            end
            for (int i = 0; i < ATTR_BYTES; i++)
            begin
                attr_prefix_reg[i] <= 8'd0;
            end
            tag_length_reg  <= 7'd0;
            attr_length_reg <= 7'd0;
            value_count_reg <= 8'd0;
            trkpt_reg       <= 1'b0;
            ele_reg         <= 1'b0;
            time_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            tag_prefix_reg  <= tag_prefix_next;
            attr_prefix_reg <= attr_prefix_next;
            tag_length_reg  <= tag_length_next;
            attr_length_reg <= attr_length_next;
            value_count_reg <= value_count_next;
            trkpt_reg       <= trkpt_next;
            ele_reg         <= ele_next;
            time_reg        <= time_next;
        end
    end

endmodule

>>> design/gpx_cmd_fifo.sv
// ----------------------------------------------------------------------------
// gpx_cmd_fifo
// Small command queue between parser and beat generator, head shown ahead.
// ----------------------------------------------------------------------------
module gpx_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gpx_pkg::cmd_t push_data,
    input  logic          pop,
    output gpx_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);
    import gpx_pkg::*;

    cmd_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> design/gpx_back.sv
// ----------------------------------------------------------------------------
// gpx_back
// Beat generator: expands each queued command into output beats (comma
// escape, end of record) and holds them in the output register.
// ----------------------------------------------------------------------------
module gpx_back (
    input  logic          clk,
    input  logic          rst_n,
    input  gpx_pkg::cmd_t head,
    input  logic          empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic [1:0]    field_id,
    output logic [1:0]    out_kind,
    output logic          last
);
    import gpx_pkg::*;

    logic [2:0] step_reg, step_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic [1:0] field_reg, kind_reg;
    logic       last_reg;

    logic       load, is_comma, beat_last;
    logic [2:0] last_step;
    logic [7:0] beat_byte;
    logic [1:0] beat_field, beat_kind;

    assign load     = !empty && (!valid_reg || out_ready);
    assign is_comma = (head.kind == CMD_DATA) && (head.data == ",");

    always_comb
    begin
        last_step  = 3'd0;
        beat_byte  = 8'd0;
        beat_field = head.field;
        beat_kind  = KIND_DATA;
        unique case (head.kind)
            CMD_DATA:
            begin
                last_step = is_comma ? ESC_LAST_STEP : 3'd0;
                beat_byte = is_comma ? escape_byte(step_reg) : head.data;
            end
            CMD_END_FIELD:
            begin
                beat_kind = KIND_END_FIELD;
            end
            CMD_END_RECORD:
            begin
                // end of time field, then end of record
                last_step = 3'd1;
                if (step_reg == 3'd0)
                begin
                    beat_kind = KIND_END_FIELD;
                end
                else
                begin
                    beat_kind  = KIND_END_RECORD;
                    beat_field = FIELD_LAT;
                end
            end
            default:
            begin
                beat_kind = KIND_DATA;
            end
        endcase
    end

    assign beat_last = (step_reg == last_step);
    assign pop       = load && beat_last;
    assign step_next = beat_last ? 3'd0 : step_reg + 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= 3'd0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                step_reg  <= step_next;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= beat_byte;
            field_reg <= beat_field;
            kind_reg  <= beat_kind;
            last_reg  <= beat_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign field_id  = field_reg;
    assign out_kind  = kind_reg;
    assign last      = last_reg;

endmodule

>>> design/gpx_checker.sv
// ----------------------------------------------------------------------------
// gpx_checker
// Port-level checks on the extractor's output stream, bound to the top level.
// ----------------------------------------------------------------------------
module gpx_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic [1:0] field_id,
    input  logic [1:0] out_kind,
    input  logic       last
);
    import gpx_pkg::*;

    // stalled beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
        $stable(out_kind) && $stable(field_id) && $stable(last))
        else $error("output beat changed while stalled");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_kind == KIND_DATA) || (out_kind == KIND_END_FIELD) ||
        (out_kind == KIND_END_RECORD))
        else $error("illegal result kind");

    a_rec_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_END_RECORD) |->
        last && (field_id == FIELD_LAT) && (out_byte == 8'd0))
        else $error("malformed end of record");

    // end of time field never carries last, as end of record follows it
    a_rec_after_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (out_kind == KIND_END_FIELD) && (field_id == FIELD_TIME)
        |-> !last)
        else $error("end of time field without end of record");

endmodule

bind gpx_track_point_extractor gpx_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .field_id  (field_id),
    .out_kind  (out_kind),
    .last      (last)
);

>>> bench/gpx_track_point_extractor_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpx_track_point_extractor_test
// Self-checking bench for the GPX track point extractor. Feeds GPX-like text
// with directed and random track points, predicts every result beat in a
// scoreboard, and compares the output beats in order. Runs through several
// value_limit settings and idle/stall mixes on both channels.
// ----------------------------------------------------------------------------
import gpx_pkg::*;

typedef struct packed {
    logic [7:0] data;
    logic [1:0] field;
    logic [1:0] kind;
    logic       tail;
} field_beat_t;

class point_scoreboard;
    localparam int NO_FIELD = 4;

    field_beat_t  pending_beats[$];
    field_beat_t  step_beats[$];
    int           errors;

    logic [7:0]   cap;
    parse_state_t pstate;
    logic [7:0]   name_buf [NAME_BYTES];
    logic [6:0]   name_len;
    logic [7:0]   attr_buf [3];
    logic [6:0]   attr_len;
    logic [7:0]   kept;
    bit           point_open;
    bit           ele_open;
    bit           time_open;

    function new();
        errors = 0;
        cap = VALUE_LIMIT_RST;
        pstate = ST_TOP;
        foreach (name_buf[i]) name_buf[i] = 8'd0;
        foreach (attr_buf[i]) attr_buf[i] = 8'd0;
        name_len = 0;
        attr_len = 0;
        kept = 0;
        point_open = 0;
        ele_open = 0;
        time_open = 0;
    endfunction

    function int pending();
        return pending_beats.size();
    endfunction

    function bit alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit blank(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // tag names compare case-blind against a lowercase word
    function bit tag_match(string w, bit exact);
        int n;
        n = w.len();
        if (name_len < n || (exact && name_len != n))
            return 0;
        for (int i = 0; i < n; i++)
            if ((name_buf[i] | 8'h20) != w[i])
                return 0;
        return 1;
    endfunction

    function bit attr_match(string w);
        if (attr_len < 3)
            return 0;
        for (int i = 0; i < 3; i++)
            if (attr_buf[i] != w[i])
                return 0;
        return 1;
    endfunction

    function void clear_attr();
        foreach (attr_buf[i]) attr_buf[i] = 8'd0;
        attr_len = 0;
    endfunction

    function void add_attr_letter(logic [7:0] c);
        if (attr_len < 3)
            attr_buf[attr_len] = c;
        if (attr_len < 127)
            attr_len++;
    endfunction

    function void put(logic [7:0] b, logic [1:0] f, logic [1:0] k);
        field_beat_t e;
        e.data = b;
        e.field = f;
        e.kind = k;
        e.tail = 1'b0;
        step_beats.push_back(e);
    endfunction

    function void put_text(logic [7:0] b, logic [1:0] f);
        string esc;
        esc = "&comma;";
        if (b == ",")
            for (int i = 0; i < 7; i++)
                put(esc[i], f, KIND_DATA);
        else
            put(b, f, KIND_DATA);
    endfunction

    // Advance the parser by one accepted byte and queue the beats it causes.
    function void note_input(logic [7:0] c);
        logic [7:0]  quote;
        int          fsel;
        field_beat_t e;
        step_beats.delete();
        case (pstate)
            ST_TOP:
            begin
                if (c == "<") begin
                    if (point_open && ele_open) begin
                        put(8'd0, FIELD_ELE, KIND_END_FIELD);
                        ele_open = 0;
                    end else if (point_open && time_open) begin
                        put(8'd0, FIELD_TIME, KIND_END_FIELD);
                        // end of record carries field code zero
                        put(8'd0, FIELD_LAT, KIND_END_RECORD);
                        time_open = 0;
                    end
                    foreach (name_buf[i]) name_buf[i] = 8'd0;
                    name_len = 0;
                    pstate = ST_TAGNAME;
                end else if (point_open && ele_open) begin
                    put_text(c, FIELD_ELE);
                end else if (point_open && time_open) begin
                    put_text(c, FIELD_TIME);
                end
            end
            ST_TAGNAME:
            begin
                if (alpha(c)) begin
                    if (name_len < NAME_BYTES)
                        name_buf[name_len] = c;
                    if (name_len < 127)
                        name_len++;
                end else if (blank(c)) begin
                    if (tag_match("trkpt", 0))
                        point_open = 1;
                    if (tag_match("ele", 1))
                        ele_open = 1;
                    else if (tag_match("time", 1))
                        time_open = 1;
                    pstate = ST_WS_TAG;
                end else if (c == ">") begin
                    if (tag_match("ele", 0))
                        ele_open = 1;
                    else if (tag_match("time", 0) && point_open)
                        time_open = 1;
                    pstate = ST_TOP;
                end else if (c == "!" || c == "?") begin
                    pstate = ST_DECL;
                end else if (c == "/") begin
                    pstate = ST_CLOSING;
                end
            end
            ST_DECL, ST_CLOSING:
            begin
                if (c == ">")
                    pstate = ST_TOP;
            end
            ST_WS_TAG:
            begin
                if (tag_match("trkpt", 0)) begin
                    if (alpha(c)) begin
                        clear_attr();
                        add_attr_letter(c);
                        pstate = ST_ATTR_NAME;
                    end else if (c == ">") begin
                        pstate = ST_TOP;
                    end
                end else if (c == ">") begin
                    pstate = ST_TOP;
                end
            end
            ST_ATTR_NAME:
            begin
                if (alpha(c))
                    add_attr_letter(c);
                else if (blank(c))
                    pstate = ST_WS_ATTRNAME;
                else if (c == "=")
                    pstate = ST_EQ;
                else if (c == ">")
                    pstate = ST_TOP;
            end
            ST_WS_ATTRNAME:
            begin
                if (c == "=")
                    pstate = ST_EQ;
            end
            ST_EQ, ST_WS_EQ:
            begin
                if (c == "'") begin
                    kept = 0;
                    pstate = ST_VAL_SQ;
                end else if (c == "\"") begin
                    kept = 0;
                    pstate = ST_VAL_DQ;
                end else if (blank(c) && pstate == ST_EQ) begin
                    pstate = ST_WS_EQ;
                end
            end
            ST_VAL_SQ, ST_VAL_DQ:
            begin
                quote = (pstate == ST_VAL_SQ) ? "'" : "\"";
                fsel = attr_match("lat") ? FIELD_LAT
                     : (attr_match("lon") ? FIELD_LON : NO_FIELD);
                if (c == quote) begin
                    if (fsel != NO_FIELD)
                        put(8'd0, fsel[1:0], KIND_END_FIELD);
                    clear_attr();
                    kept = 0;
                    pstate = ST_WS_TAG;
                end else if (kept < cap) begin
                    kept++;
                    if (fsel != NO_FIELD)
                        put_text(c, fsel[1:0]);
                end
            end
            default:
            begin
                pstate = ST_TOP;
            end
        endcase
        if (step_beats.size() > 0) begin
            e = step_beats.pop_back();
            e.tail = 1'b1;
            step_beats.push_back(e);
        end
        foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
    endfunction

    task report(string msg);
        errors++;
        $display("%0t ERROR %s", $time, msg);
    endtask

    task check(logic [7:0] b, logic [1:0] f, logic [1:0] k, logic l);
        field_beat_t e;
        if (pending_beats.size() == 0) begin
            report($sformatf("unexpected beat byte=%02h field=%0d kind=%0d last=%0b",
                             b, f, k, l));
            return;
        end
        e = pending_beats.pop_front();
        if (b !== e.data)
            report($sformatf("out_byte %02h, want %02h", b, e.data));
        if (f !== e.field)
            report($sformatf("field_id %0d, want %0d", f, e.field));
        if (k !== e.kind)
            report($sformatf("out_kind %0d, want %0d", k, e.kind));
        if (l !== e.tail)
            report($sformatf("last %0b, want %0b", l, e.tail));
    endtask
endclass

module gpx_track_point_extractor_test;
    localparam int STALL_LIMIT = 5000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        in_byte;
    logic              out_valid;
    logic              out_ready;
    logic [7:0]        out_byte;
    logic [1:0]        field_id;
    logic [1:0]        out_kind;
    logic              last;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    point_scoreboard board = new();
    logic [7:0]      text_q[$];
    int              src_idle_pct = 0;
    int              sink_stall_pct = 0;
    int              quiet_cycles = 0;

    gpx_track_point_extractor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .field_id  (field_id),
        .out_kind  (out_kind),
        .last      (last),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // beat monitor and quiet-cycle counter
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && in_valid && in_ready)
                board.note_input(in_byte);
            if (rst_n && out_valid && out_ready)
                board.check(out_byte, field_id, out_kind, last);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // write value_limit, then read it back
    task automatic set_limit(input logic [7:0] val);
        for (int rd = 0; rd < 2; rd++) begin
            @(negedge clk);
            psel = 1'b1;
            penable = 1'b0;
            pwrite = (rd == 0);
            paddr = ADDR_VALUE_LIMIT;
            pwdata = {24'd0, val};
            @(negedge clk);
            penable = 1'b1;
            do @(posedge clk); while (!pready);
            if (rd == 0)
                board.cap = val;
            else if (prdata !== {24'd0, val})
                board.report($sformatf("value_limit reads %08h, want %02h", prdata, val));
            @(negedge clk);
            psel = 1'b0;
            penable = 1'b0;
            pwrite = 1'b0;
        end
    endtask

    task automatic send_text();
        logic [7:0] b;
        while (text_q.size() > 0) begin
            b = text_q.pop_front();
            @(negedge clk);
            while ($urandom_range(99) < src_idle_pct) begin
                in_valid = 1'b0;
                @(negedge clk);
            end
            in_valid = 1'b1;
            in_byte = b;
            do @(posedge clk); while (!in_ready);
        end
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function automatic void add_blank();
        case ($urandom_range(3))
            0: add_str("\t");
            1: add_str("\n");
            2: add_str("\r");
            default: add_str(" ");
        endcase
    endfunction

    // attribute value: mostly numeric, some raw bytes, sometimes long
    function automatic void add_value(logic [7:0] quote);
        string      pool;
        int         n;
        logic [7:0] c;
        pool = "0123456789.-,";
        n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(7) == 0) begin
                c = $urandom_range(255);
                if (c == quote)
                    c = "x";
            end else begin
                c = pool[$urandom_range(pool.len() - 1)];
            end
            text_q.push_back(c);
        end
    endfunction

    function automatic void add_text();
        string      pool;
        int         n;
        logic [7:0] c;
        pool = "0123456789:-T.Z,";
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(5) == 0) begin
                c = $urandom_range(255);
                if (c == "<")
                    c = ">";
            end else begin
                c = pool[$urandom_range(pool.len() - 1)];
            end
            text_q.push_back(c);
        end
    endfunction

    function automatic void add_element(bit is_time);
        string opener;
        case ($urandom_range(5))
            0: opener = is_time ? "<TIME>" : "<ELE>";
            1: opener = is_time ? "<time zone='z'>" : "<ele u=\"m\">";
            2: opener = is_time ? "<timestamp>" : "<elevation>";
            default: opener = is_time ? "<time>" : "<ele>";
        endcase
        add_str(opener);
        add_text();
        add_str(is_time ? "</time>" : "</ele>");
    endfunction

    function automatic void add_point();
        logic [7:0] quote;
        int         n;
        add_str("<");
        case ($urandom_range(4))
            0: add_str("TRKPT");
            1: add_str("TrkPt");
            2: add_str("trkptx");
            default: add_str("trkpt");
        endcase
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            add_blank();
            case ($urandom_range(7))
                0: add_str("latitude");
                1: add_str("lo");
                2: add_str("LAT");
                3: add_str("ele");
                4, 5: add_str("lat");
                default: add_str("lon");
            endcase
            if ($urandom_range(3) == 0)
                add_blank();
            add_str("=");
            if ($urandom_range(3) == 0)
                add_blank();
            quote = $urandom_range(1) ? "\"" : "'";
            text_q.push_back(quote);
            add_value(quote);
            text_q.push_back(quote);
        end
        if ($urandom_range(2) == 0)
            add_blank();
        add_str(">");
        if ($urandom_range(4) != 0)
            add_element(0);
        if ($urandom_range(4) != 0)
            add_element(1);
        add_str("</trkpt>");
    endfunction

    // declarations, foreign tags, cut-off points and raw noise
    function automatic void add_misc();
        case ($urandom_range(6))
            0: add_str("<?xml version=\"1.0\"?>");
            1: add_str("<!-- a,b -->");
            2: add_str("<gpx creator='x,y'>");
            3: add_str("<name>a,b</name>");
            4: add_str("<trkpt lat=\"5");
            default:
                repeat ($urandom_range(1, 6)) text_q.push_back($urandom_range(255));
        endcase
    endfunction

    function automatic void gen_chunk(int target);
        while (text_q.size() < target) begin
            if ($urandom_range(9) < 7)
                add_point();
            else
                add_misc();
        end
    endfunction

    initial
    begin
        logic [7:0] lim;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = 8'd0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = 32'd0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        set_limit(VALUE_LIMIT_RST);
        // declarations, attributes outside a point, both quote styles, commas
        add_str("<?xml v='1'?><gpx a=\"b\"><TrkPt lat=\"-1,5\" lon='2' >");
        add_str("<ele>0,</ele><time>T</time>");
        // stray extremes, digit inside a tag name, long names
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        add_str("<e1le>");
        text_q.push_back(8'hFF);
        text_q.push_back(8'h80);
        add_str("</e><trkptlong latx='7,'><timestamp>z</timestamp>");
        send_text();
        drain();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  lim = 8'd1;   end
                1: begin src_idle_pct = 72; sink_stall_pct = 0;  lim = 8'd255; end
                2: begin src_idle_pct = 0;  sink_stall_pct = 72; lim = 8'd3;   end
                default:
                begin
                    src_idle_pct = 23;
                    sink_stall_pct = 23;
                    lim = $urandom_range(1, 255);
                end
            endcase
            set_limit(lim);
            gen_chunk(40);
            send_text();
            // hold the sender off until every beat is out
            drain();
        end

        repeat (16) @(posedge clk);
        if (board.pending() != 0)
            board.report($sformatf("%0d beats never arrived", board.pending()));
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> filelist.f
design/gpx_pkg.sv
design/gpx_front.sv
design/gpx_cmd_fifo.sv
design/gpx_back.sv
design/gpx_track_point_extractor.sv
design/gpx_checker.sv
bench/gpx_track_point_extractor_test.sv
